// File: rtl/modbus_rtu_read_holding_master_defines.svh
// ----------------------------------------------------------------------------
// Modbus RTU read-holding master: assertion macros
// Shared assertion forms, clocked on clk and muted while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef MODBUS_RTU_READ_HOLDING_MASTER_DEFINES_SVH
`define MODBUS_RTU_READ_HOLDING_MASTER_DEFINES_SVH

// Same-cycle implication.
`define MBRTU_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define MBRTU_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/mbrtu_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mbrtu_pkg
// Types, codes and CRC helper for the Modbus RTU read-holding master.
// ----------------------------------------------------------------------------
package mbrtu_pkg;

  localparam int REPLY_BYTES_DEF = 64;
  localparam int MAX_REGS_DEF    = 29;

  localparam logic [7:0]  FUNC_READ   = 8'h03;
  localparam logic [15:0] CRC_INIT    = 16'hFFFF;
  localparam logic [15:0] CRC_POLY    = 16'hA001;
  localparam logic [16:0] ELAPSED_MAX = 17'h1FFFF;

  typedef enum logic [1:0] {
    CMD_START,
    CMD_BYTE,
    CMD_TICK,
    CMD_NOP
  } cmd_t;

  typedef enum logic [1:0] {
    KIND_TX,
    KIND_REG,
    KIND_STATUS
  } kind_t;

  typedef enum logic [2:0] {
    STAT_OK,
    STAT_PARAM,
    STAT_TIMEOUT,
    STAT_ADDR,
    STAT_FUNC,
    STAT_BCOUNT,
    STAT_CRC
  } status_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_REQ_CRC,
    ST_TX,
    ST_WAIT,
    ST_FIN0,
    ST_FIN1,
    ST_FIN2,
    ST_FIN3,
    ST_FIN4,
    ST_FIN5,
    ST_RD_HI,
    ST_RD_LO,
    ST_EMIT,
    ST_STAT
  } state_t;

  // Fold one byte into a CRC-16/Modbus, reflected form.
  function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

// File: rtl/modbus_rtu_read_holding_master.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// modbus_rtu_read_holding_master
// Modbus RTU master for function 03: builds the request, gathers the reply
// into a byte RAM, checks it and streams out request bytes, register values and a status.
// ----------------------------------------------------------------------------
//
//  channel | ports                                         | handshake
//  --------+-----------------------------------------------+--------------
//  in      | in_cmd in_start_address in_count in_timeout_ms| in_valid/ready
//          | in_rx_byte                                    |
//  out     | out_kind out_data out_status out_last         | out_valid/ready
//  cfg     | cfg_wdata (device address)                    | cfg_we
//
// Sequence: a valid start runs ST_REQ_CRC over the six request bytes, then
// sends 8 transmit beats. The reply check walks the reply RAM through its
// single read port: header and CRC reads in ST_FIN0 to ST_FIN5, then
// ST_RD_HI, ST_RD_LO and ST_EMIT per register, and one status beat.
// Reset: rst_n is synchronous, active low; the reply RAM needs no clearing.
// Stalls: every beat lands in one output register; the sequencer holds while
// that register is full and out_ready is low. Input is taken only in idle
// and while waiting for reply bytes.
// ----------------------------------------------------------------------------
`include "modbus_rtu_read_holding_master_defines.svh"

module modbus_rtu_read_holding_master
  import mbrtu_pkg::*;
#(
  parameter int REPLY_BYTES = REPLY_BYTES_DEF,
  parameter int MAX_REGS    = MAX_REGS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [7:0]  cfg_wdata,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_cmd,
  input  logic [15:0] in_start_address,
  input  logic [15:0] in_count,
  input  logic [15:0] in_timeout_ms,
  input  logic [7:0]  in_rx_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_kind,
  output logic [15:0] out_data,
  output logic [2:0]  out_status,
  output logic        out_last
);

  localparam int AW   = $clog2(REPLY_BYTES);      // reply RAM address
  localparam int BR_W = $clog2(REPLY_BYTES + 1);  // byte count up to full RAM
  localparam int RC_W = $clog2(MAX_REGS + 1);     // register count

  // --------------------------------------------------------------------------
  // State
  // --------------------------------------------------------------------------
  state_t            state_r, state_nxt;
  logic [7:0]        dev_addr_r;
  logic [BR_W-1:0]   bytes_rcvd_r, bytes_rcvd_nxt;
  logic [15:0]       crc_r, crc_nxt;
  logic [16:0]       elapsed_r, elapsed_nxt;
  logic [15:0]       timeout_r, timeout_nxt;
  logic [RC_W-1:0]   reg_count_r, reg_count_nxt;
  logic [RC_W-1:0]   reg_idx_r, reg_idx_nxt;
  logic [2:0]        tx_idx_r, tx_idx_nxt;
  logic [7:0]        req_addr_r, req_addr_nxt;
  logic [15:0]       sa_r, sa_nxt;
  logic [15:0]       req_crc_r, req_crc_nxt;
  logic [7:0]        crc_lo_r, crc_lo_nxt;
  logic [7:0]        hi_r, hi_nxt;
  status_t           stat_r, stat_nxt;

  logic              out_valid_r;
  kind_t             out_kind_r;
  logic [15:0]       out_data_r;
  status_t           out_status_r;
  logic              out_last_r;

  // Reply RAM, one write and one registered read per cycle
  logic [7:0]        reply_mem [REPLY_BYTES];
  logic [7:0]        mem_q;
  logic [AW-1:0]     rd_addr;
  logic              mem_we;

  // --------------------------------------------------------------------------
  // Shared terms
  // --------------------------------------------------------------------------
  cmd_t              in_cmd_e;
  logic              in_fire;
  logic              out_free;
  logic              waiting;
  logic [BR_W-1:0]   need;
  logic [BR_W-1:0]   need_m2;
  logic [BR_W-1:0]   need_m1;
  logic              last_byte;
  logic [17:0]       req_len;
  logic              start_bad;
  logic [16:0]       elapsed_inc;
  logic              expire;
  logic [BR_W-1:0]   hi_off;
  logic [BR_W-1:0]   lo_off;
  logic              last_reg;
  logic [7:0]        bcount;
  logic [15:0]       cnt16;
  logic [7:0]        req_byte;

  logic              emit;
  kind_t             emit_kind;
  logic [15:0]       emit_data;
  status_t           emit_status;
  logic              emit_last;

  assign in_cmd_e    = cmd_t'(in_cmd);
  assign in_fire     = in_valid && in_ready;
  assign out_free    = !out_valid_r || out_ready;
  assign waiting     = (state_r == ST_WAIT);
  assign need        = BR_W'({reg_count_r, 1'b0}) + BR_W'(5);
  assign need_m2     = need - BR_W'(2);
  assign need_m1     = need - BR_W'(1);
  assign last_byte   = (BR_W'(bytes_rcvd_r + 1'b1) == need);
  assign req_len     = 18'd5 + {1'b0, in_count, 1'b0};
  assign start_bad   = (in_count == 16'd0) || (in_count > 16'(MAX_REGS)) ||
                       (req_len > 18'(REPLY_BYTES));
  assign elapsed_inc = (elapsed_r == ELAPSED_MAX) ? elapsed_r : elapsed_r + 17'd1;
  assign expire      = (elapsed_inc > {1'b0, timeout_r});
  assign hi_off      = BR_W'({reg_idx_r, 1'b0}) + BR_W'(3);
  assign lo_off      = hi_off + BR_W'(1);
  assign last_reg    = (reg_idx_r == RC_W'(reg_count_r - 1'b1));
  assign bcount      = 8'({reg_count_r, 1'b0});
  assign cnt16       = 16'(reg_count_r);

  // Request byte for the current transmit slot
  always_comb begin
    unique case (tx_idx_r)
      3'd0: req_byte = req_addr_r;
      3'd1: req_byte = FUNC_READ;
      3'd2: req_byte = sa_r[15:8];
      3'd3: req_byte = sa_r[7:0];
      3'd4: req_byte = cnt16[15:8];
      3'd5: req_byte = cnt16[7:0];
      3'd6: req_byte = req_crc_r[7:0];
      3'd7: req_byte = req_crc_r[15:8];
    endcase
  end

  // --------------------------------------------------------------------------
  // Next state
  // --------------------------------------------------------------------------
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE, ST_WAIT: begin
        if (in_fire) begin
          unique case (in_cmd_e)
            CMD_START: state_nxt = start_bad ? ST_STAT : ST_REQ_CRC;
            CMD_BYTE:  if (waiting && last_byte) state_nxt = ST_FIN0;
            CMD_TICK:  if (waiting && expire) state_nxt = ST_STAT;
            CMD_NOP:   state_nxt = state_r;
          endcase
        end
      end
      ST_REQ_CRC: if (tx_idx_r == 3'd5) state_nxt = ST_TX;
      ST_TX:      if (out_free && tx_idx_r == 3'd7) state_nxt = ST_WAIT;
      ST_FIN0:    state_nxt = ST_FIN1;
      ST_FIN1:    state_nxt = (mem_q != dev_addr_r) ? ST_STAT : ST_FIN2;
      ST_FIN2:    state_nxt = (mem_q != FUNC_READ) ? ST_STAT : ST_FIN3;
      ST_FIN3:    state_nxt = (mem_q != bcount) ? ST_STAT : ST_FIN4;
      ST_FIN4:    state_nxt = ST_FIN5;
      ST_FIN5:    state_nxt = ({mem_q, crc_lo_r} != crc_r) ? ST_STAT : ST_RD_HI;
      ST_RD_HI:   state_nxt = ST_RD_LO;
      ST_RD_LO:   state_nxt = ST_EMIT;
      ST_EMIT:    if (out_free) state_nxt = last_reg ? ST_STAT : ST_RD_HI;
      ST_STAT:    if (out_free) state_nxt = ST_IDLE;
      default:    state_nxt = ST_IDLE;
    endcase
  end

  // --------------------------------------------------------------------------
  // Outputs of the sequencer: handshake, beat to emit, RAM access
  // --------------------------------------------------------------------------
  always_comb begin
    in_ready    = 1'b0;
    emit        = 1'b0;
    emit_kind   = KIND_TX;
    emit_data   = 16'h0000;
    emit_status = STAT_OK;
    emit_last   = 1'b0;
    rd_addr     = '0;
    mem_we      = 1'b0;
    unique case (state_r)
      ST_IDLE: in_ready = 1'b1;
      ST_WAIT: begin
        in_ready = 1'b1;
        mem_we   = in_fire && (in_cmd_e == CMD_BYTE);
      end
      ST_TX: begin
        emit      = 1'b1;
        emit_kind = KIND_TX;
        emit_data = {8'h00, req_byte};
      end
      ST_FIN0: rd_addr = AW'(0);
      ST_FIN1: rd_addr = AW'(1);
      ST_FIN2: rd_addr = AW'(2);
      ST_FIN3: rd_addr = need_m2[AW-1:0];
      ST_FIN4: rd_addr = need_m1[AW-1:0];
      ST_RD_HI: rd_addr = hi_off[AW-1:0];
      ST_RD_LO: rd_addr = lo_off[AW-1:0];
      ST_EMIT: begin
        // keep the low byte address so mem_q holds through a stall
        rd_addr   = lo_off[AW-1:0];
        emit      = 1'b1;
        emit_kind = KIND_REG;
        emit_data = {hi_r, mem_q};
      end
      ST_STAT: begin
        emit        = 1'b1;
        emit_kind   = KIND_STATUS;
        emit_status = stat_r;
        emit_last   = 1'b1;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

  // --------------------------------------------------------------------------
  // Datapath next values
  // --------------------------------------------------------------------------
  always_comb begin
    bytes_rcvd_nxt = bytes_rcvd_r;
    crc_nxt        = crc_r;
    elapsed_nxt    = elapsed_r;
    timeout_nxt    = timeout_r;
    reg_count_nxt  = reg_count_r;
    reg_idx_nxt    = reg_idx_r;
    tx_idx_nxt     = tx_idx_r;
    req_addr_nxt   = req_addr_r;
    sa_nxt         = sa_r;
    req_crc_nxt    = req_crc_r;
    crc_lo_nxt     = crc_lo_r;
    hi_nxt         = hi_r;
    stat_nxt       = stat_r;
    unique case (state_r)
      ST_IDLE, ST_WAIT: begin
        if (in_fire) begin
          unique case (in_cmd_e)
            CMD_START: begin
              // drop any exchange in flight and start over
              bytes_rcvd_nxt = '0;
              elapsed_nxt    = '0;
              crc_nxt        = CRC_INIT;
              if (start_bad) begin
                stat_nxt = STAT_PARAM;
              end else begin
                req_addr_nxt  = dev_addr_r;
                sa_nxt        = in_start_address;
                reg_count_nxt = RC_W'(in_count);
                timeout_nxt   = in_timeout_ms;
                req_crc_nxt   = CRC_INIT;
                tx_idx_nxt    = 3'd0;
              end
            end
            CMD_BYTE: begin
              if (waiting) begin
                if (bytes_rcvd_r < need_m2) crc_nxt = crc_byte(crc_r, in_rx_byte);
                bytes_rcvd_nxt = BR_W'(bytes_rcvd_r + 1'b1);
              end
            end
            CMD_TICK: begin
              if (waiting) begin
                elapsed_nxt = elapsed_inc;
                if (expire) stat_nxt = STAT_TIMEOUT;
              end
            end
            CMD_NOP: stat_nxt = stat_r;
          endcase
        end
      end
      ST_REQ_CRC: begin
        req_crc_nxt = crc_byte(req_crc_r, req_byte);
        tx_idx_nxt  = (tx_idx_r == 3'd5) ? 3'd0 : tx_idx_r + 3'd1;
      end
      ST_TX:   if (out_free) tx_idx_nxt = tx_idx_r + 3'd1;
      ST_FIN1: if (mem_q != dev_addr_r) stat_nxt = STAT_ADDR;
      ST_FIN2: if (mem_q != FUNC_READ) stat_nxt = STAT_FUNC;
      ST_FIN3: if (mem_q != bcount) stat_nxt = STAT_BCOUNT;
      ST_FIN4: crc_lo_nxt = mem_q;
      ST_FIN5: begin
        reg_idx_nxt = '0;
        if ({mem_q, crc_lo_r} != crc_r) stat_nxt = STAT_CRC;
      end
      ST_RD_LO: hi_nxt = mem_q;
      ST_EMIT: begin
        if (out_free) begin
          reg_idx_nxt = RC_W'(reg_idx_r + 1'b1);
          if (last_reg) stat_nxt = STAT_OK;
        end
      end
      ST_STAT: begin
        if (out_free) begin
          bytes_rcvd_nxt = '0;
          elapsed_nxt    = '0;
          crc_nxt        = CRC_INIT;
        end
      end
      default: stat_nxt = stat_r;
    endcase
  end

  // --------------------------------------------------------------------------
  // Registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      dev_addr_r   <= 8'd1;
      bytes_rcvd_r <= '0;
      crc_r        <= CRC_INIT;
      elapsed_r    <= '0;
      timeout_r    <= '0;
      reg_count_r  <= '0;
      reg_idx_r    <= '0;
      tx_idx_r     <= '0;
      stat_r       <= STAT_OK;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      if (cfg_we) dev_addr_r <= cfg_wdata;
      bytes_rcvd_r <= bytes_rcvd_nxt;
      crc_r        <= crc_nxt;
      elapsed_r    <= elapsed_nxt;
      timeout_r    <= timeout_nxt;
      reg_count_r  <= reg_count_nxt;
      reg_idx_r    <= reg_idx_nxt;
      tx_idx_r     <= tx_idx_nxt;
      stat_r       <= stat_nxt;
      if (emit && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers, no reset
  always_ff @(posedge clk) begin
    req_addr_r <= req_addr_nxt;
    sa_r       <= sa_nxt;
    req_crc_r  <= req_crc_nxt;
    crc_lo_r   <= crc_lo_nxt;
    hi_r       <= hi_nxt;
    if (emit && out_free) begin
      out_kind_r   <= emit_kind;
      out_data_r   <= emit_data;
      out_status_r <= emit_status;
      out_last_r   <= emit_last;
    end
  end

  // Reply RAM
  always_ff @(posedge clk) begin
    if (mem_we) reply_mem[bytes_rcvd_r[AW-1:0]] <= in_rx_byte;
    mem_q <= reply_mem[rd_addr];
  end

  assign out_valid  = out_valid_r;
  assign out_kind   = out_kind_r;
  assign out_data   = out_data_r;
  assign out_status = out_status_r;
  assign out_last   = out_last_r;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  `MBRTU_ASSERT_NOW(a_wait_room, state_r == ST_WAIT, bytes_rcvd_r < need, "reply overran expected length")
  `MBRTU_ASSERT_NOW(a_last_is_status, out_valid && out_last, out_kind_r == KIND_STATUS, "last beat not a status")
  `MBRTU_ASSERT_NOW(a_reg_idx_range, state_r == ST_RD_HI, reg_idx_r < reg_count_r, "register index past count")

endmodule
